/* hw/rtl/apm_pkg.sv */
// apm_pkg: shared types, codes and constants of the audio level meter
// no dependencies; imported by every module of the meter
package apm_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [15:0] sample;
    logic               block_last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] peak_level_db;
    logic signed [15:0] rms_level_db;
    logic [19:0]        age_ms;
  } out_item_t;

  // configuration register indexes
  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_STALE = 1'b1;

  localparam int MAX_BLOCK_SAMPLES_DEF = 4096;

  localparam logic signed [15:0] DB_FLOOR     = -16'sd30720;
  localparam logic [15:0]        DB_FLOOR_MAG = 16'd30720;
  localparam logic [31:0]        RMS_FLOOR    = 32'd2147;
  localparam logic [31:0]        LIN_FULL     = 32'h8000_0000;
  localparam logic [19:0]        AGE_MAX      = 20'd999999;
  localparam logic [18:0]        DB_PER_LOG2  = 19'd394566;
  localparam logic [16:0]        ALPHA_ONE    = 17'd65536;
  localparam logic [16:0]        ALPHA_RESET  = 17'd19661;
  localparam logic [19:0]        STALE_RESET  = 20'd500;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic tick;
    logic clear;
    logic sq;
    logic acc;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic log_init;
    logic log_sel;     // 1 smoothed rms, 0 block peak
    logic log_norm;
    logic log_sq;
    logic log_mul;
    logic log_fin;
    logic store_peak;
    logic mix1;
    logic mix2;
    logic fin;
    logic load_out;
  } apm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic log_zero;
    logic log_normed;
    logic div_last;
    logic sqrt_last;
    logic sq_last;
  } apm_sts_t;

endpackage

/* hw/rtl/apm_datapath.sv */
// apm_datapath: accumulators, divider, square root, log unit and smoothing
// depends on apm_pkg; driven by apm_ctrl
module apm_datapath import apm_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = MAX_BLOCK_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  apm_cmd_t           cmd,
  output apm_sts_t           sts,
  input  logic signed [15:0] sample,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [19:0]        cfg_data,
  output out_item_t          out_item
);

  localparam int CW  = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int SW  = 30 + CW;
  localparam int DW  = SW + 32;
  localparam int ITW = $clog2(DW);

  logic [16:0] alpha;
  logic [19:0] stale_lim;

  logic [15:0]        cur_sample_mag;
  logic [31:0]        sq;
  logic [15:0]        blk_peak;
  logic [SW-1:0]      blk_sum;
  logic [CW-1:0]      blk_cnt;
  logic signed [15:0] held_peak;
  logic [31:0]        smoothed;
  logic [19:0]        ticks;
  logic               fed;

  logic [ITW-1:0] cnt;
  logic [DW-1:0]  dvd;
  logic [CW-1:0]  rem;
  logic [63:0]    sv, sr, sb;

  logic               lzero;
  logic [30:0]        ly;
  logic [4:0]         le;
  logic [15:0]        lfrac;
  logic [15:0]        lmag;
  logic signed [15:0] db_res;
  logic [48:0]        p1, macc;

  logic [15:0] mag;
  logic [CW:0] trial;
  logic        qbit;
  logic [63:0] st;
  logic [31:0] lx;
  logic [61:0] lsq;
  logic [20:0] lneg;
  logic [39:0] lprod;
  logic [16:0] a_eff;
  logic [32:0] mix;
  logic [19:0] age;
  logic        stale;

  always_comb begin
    mag   = sample[15] ? 16'(~sample) + 16'd1 : 16'(sample);
    trial = {rem, dvd[DW-1]};
    qbit  = trial >= {1'b0, blk_cnt};
    st    = sr + sb;
    lx    = cmd.log_sel ? smoothed : {blk_peak, 16'd0};
    lsq   = 62'(ly) * 62'(ly);
    lneg  = 21'({5'd31, 16'd0}) - {le, lfrac};
    lprod = 40'(lneg) * 40'(DB_PER_LOG2) + 40'h80_0000;
    a_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    mix   = macc[48:16];
    age   = fed ? ticks : AGE_MAX;
    stale = !fed || (age > stale_lim);
  end

  assign sts.log_zero   = lzero;
  assign sts.log_normed = ly[30];
  assign sts.div_last   = cnt == ITW'(DW - 1);
  assign sts.sqrt_last  = cnt == ITW'(31);
  assign sts.sq_last    = cnt == ITW'(15);

  // configuration and meter state
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RESET;
      stale_lim <= STALE_RESET;
      blk_peak  <= '0;
      blk_sum   <= '0;
      blk_cnt   <= '0;
      held_peak <= DB_FLOOR;
      smoothed  <= RMS_FLOOR;
      ticks     <= '0;
      fed       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ALPHA: alpha     <= cfg_data[16:0];
          CFG_STALE: stale_lim <= cfg_data;
          default:   alpha     <= alpha;
        endcase
      end
      if (cmd.clear) begin
        blk_peak  <= '0;
        blk_sum   <= '0;
        blk_cnt   <= '0;
        held_peak <= DB_FLOOR;
        smoothed  <= RMS_FLOOR;
        ticks     <= '0;
        fed       <= 1'b0;
      end
      if (cmd.tick && ticks < AGE_MAX) ticks <= ticks + 20'd1;
      if (cmd.acc && blk_cnt < CW'(MAX_BLOCK_SAMPLES)) begin
        if (cur_sample_mag > blk_peak) blk_peak <= cur_sample_mag;
        blk_sum <= blk_sum + SW'(sq);
        blk_cnt <= blk_cnt + CW'(1);
      end
      if (cmd.store_peak) held_peak <= db_res;
      if (cmd.fin) begin
        if (mix < 33'(RMS_FLOOR))     smoothed <= RMS_FLOOR;
        else if (mix > 33'(LIN_FULL)) smoothed <= LIN_FULL;
        else                          smoothed <= mix[31:0];
        ticks    <= '0;
        fed      <= 1'b1;
        blk_peak <= '0;
        blk_sum  <= '0;
        blk_cnt  <= '0;
      end
    end
  end

  // working registers of the block-end and read arithmetic
  always_ff @(posedge clk) begin
    if (cmd.capture) cur_sample_mag <= mag;
    if (cmd.sq) sq <= 32'(cur_sample_mag) * 32'(cur_sample_mag);

    if (cmd.div_init || cmd.sqrt_init || cmd.log_init) cnt <= '0;
    else if (cmd.div_step || cmd.sqrt_step || cmd.log_sq) cnt <= cnt + ITW'(1);

    // restoring division of sum * 2^32 by the sample count
    if (cmd.div_init) begin
      dvd <= {blk_sum, 32'd0};
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[DW-2:0], qbit};
      rem <= qbit ? CW'(trial - {1'b0, blk_cnt}) : CW'(trial);
    end

    // bitwise integer square root
    if (cmd.sqrt_init) begin
      sv <= 64'(dvd);
      sr <= '0;
      sb <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (sv >= st) begin
        sv <= sv - st;
        sr <= (sr >> 1) + sb;
      end else begin
        sr <= sr >> 1;
      end
      sb <= sb >> 2;
    end

    // log2 by normalise then repeated squaring
    if (cmd.log_init) begin
      lzero <= lx == 32'd0;
      lfrac <= '0;
      if (lx[31]) begin
        ly <= lx[31:1];
        le <= 5'd31;
      end else begin
        ly <= lx[30:0];
        le <= 5'd30;
      end
    end else if (cmd.log_norm) begin
      ly <= {ly[29:0], 1'b0};
      le <= le - 5'd1;
    end else if (cmd.log_sq) begin
      if (lsq[61]) begin
        ly    <= lsq[61:31];
        lfrac <= {lfrac[14:0], 1'b1};
      end else begin
        ly    <= lsq[60:30];
        lfrac <= {lfrac[14:0], 1'b0};
      end
    end
    if (cmd.log_mul) lmag <= lprod[39:24];
    if (cmd.log_fin) begin
      if (lzero || lmag > DB_FLOOR_MAG) db_res <= DB_FLOOR;
      else                              db_res <= -$signed(lmag);
    end

    // exponential smoothing, one product per cycle
    if (cmd.mix1) p1 <= 49'(smoothed) * 49'(ALPHA_ONE - a_eff);
    if (cmd.mix2) macc <= p1 + 49'(sr[31:0]) * 49'(a_eff) + 49'd32768;

    if (cmd.load_out) begin
      out_item.peak_level_db <= stale ? DB_FLOOR : held_peak;
      out_item.rms_level_db  <= stale ? DB_FLOOR : db_res;
      out_item.age_ms        <= age;
    end
  end

endmodule

/* hw/rtl/apm_ctrl.sv */
// apm_ctrl: sequencer of the level meter, one item at a time
// depends on apm_pkg; drives apm_datapath
module apm_ctrl import apm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  op_t      opcode,
  input  logic     block_last,
  output logic     out_valid,
  input  logic     out_stall,
  output apm_cmd_t cmd,
  input  apm_sts_t sts
);

  typedef enum logic [3:0] {
    IDLE, SQ, ACC, DIV_INIT, DIV, SQRT_INIT, SQRT, LOG_INIT, LOG_NORM,
    LOG_SQ, LOG_MUL, LOG_FIN, STORE, MIX2, FIN, OUT
  } state_t;

  state_t state;
  logic   last;
  logic   rd_mode;
  logic   accept;
  logic   out_free;

  assign in_stall = state != IDLE;
  assign accept   = in_valid && state == IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd         = '0;
    cmd.log_sel = rd_mode;
    unique case (state)
      IDLE: begin
        cmd.capture = accept;
        cmd.tick    = accept && opcode == OP_TICK;
        cmd.clear   = accept && opcode == OP_CLEAR;
      end
      SQ:        cmd.sq = 1'b1;
      ACC:       cmd.acc = 1'b1;
      DIV_INIT:  cmd.div_init = 1'b1;
      DIV:       cmd.div_step = 1'b1;
      SQRT_INIT: cmd.sqrt_init = 1'b1;
      SQRT:      cmd.sqrt_step = 1'b1;
      LOG_INIT:  cmd.log_init = 1'b1;
      LOG_NORM:  cmd.log_norm = !sts.log_zero && !sts.log_normed;
      LOG_SQ:    cmd.log_sq = 1'b1;
      LOG_MUL:   cmd.log_mul = 1'b1;
      LOG_FIN:   cmd.log_fin = 1'b1;
      STORE: begin
        cmd.store_peak = 1'b1;
        cmd.mix1       = 1'b1;
      end
      MIX2:      cmd.mix2 = 1'b1;
      FIN:       cmd.fin = 1'b1;
      OUT:       cmd.load_out = out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      last      <= 1'b0;
      rd_mode   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == OUT && out_free) out_valid <= 1'b1;
      else if (!out_stall)          out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            last <= block_last;
            unique case (opcode)
              OP_SAMPLE: state <= SQ;
              OP_READ: begin
                rd_mode <= 1'b1;
                state   <= LOG_INIT;
              end
              OP_TICK:  state <= IDLE;
              OP_CLEAR: state <= IDLE;
              default:  state <= IDLE;
            endcase
          end
        end
        SQ:        state <= ACC;
        ACC:       state <= last ? DIV_INIT : IDLE;
        DIV_INIT:  state <= DIV;
        DIV:       if (sts.div_last) state <= SQRT_INIT;
        SQRT_INIT: state <= SQRT;
        SQRT: begin
          if (sts.sqrt_last) begin
            rd_mode <= 1'b0;
            state   <= LOG_INIT;
          end
        end
        LOG_INIT:  state <= LOG_NORM;
        LOG_NORM: begin
          if (sts.log_zero)        state <= LOG_FIN;
          else if (sts.log_normed) state <= LOG_SQ;
        end
        LOG_SQ:    if (sts.sq_last) state <= LOG_MUL;
        LOG_MUL:   state <= LOG_FIN;
        LOG_FIN:   state <= rd_mode ? OUT : STORE;
        STORE:     state <= MIX2;
        MIX2:      state <= FIN;
        FIN:       state <= IDLE;
        OUT: begin
          if (out_free) begin
            rd_mode   <= 1'b0;
            state     <= IDLE;
          end
        end
        default:   state <= IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/audio_peak_rms_dbfs_meter_top.sv */
// audio_peak_rms_dbfs_meter_top: top level of the peak / rms dBFS level meter
// depends on apm_pkg, apm_ctrl and apm_datapath
//
// input channel: in_valid / in_stall with in_item (opcode, sample, block_last)
//   sample items feed a block, tick items age the reading, read items return a
//   snapshot, clear items reset levels and age (registers are kept)
// output channel: out_valid / out_stall with out_item, one item per read
// configuration: cfg_we writes cfg_data to register cfg_index (0 smoothing alpha,
//   1 stale limit); the user must write only while the meter is idle (unchecked)
// sequencing, one item in flight at a time:
//   tick and clear return straight to idle, a sample inside a block runs a
//   square and an accumulate step; the sample closing a block adds the
//   block-end work: a bit-serial divide, a bitwise square root, the log unit
//   on the block peak and the smoothing steps
//   the log unit normalises, then squares once per fraction bit
//   a read runs the smoothed rms through the log unit before the result lands
// the result sits in an output register; other items are still taken while
// it waits, a further read holds until the receiver has taken it
// reset (synchronous, active high) restores registers and meter to defaults
module audio_peak_rms_dbfs_meter_top import apm_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = MAX_BLOCK_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  apm_cmd_t cmd;
  apm_sts_t sts;

  // sequencer: one state per step of the block-end and read arithmetic
  apm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (in_item.opcode),
    .block_last (in_item.block_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  // accumulators, divider, root, shared log unit and the result register
  apm_datapath #(
    .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (in_item.sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

endmodule

/* tb/tb.sv */
// tb: self-checking testbench of the peak / rms dBFS level meter
// depends on apm_pkg and audio_peak_rms_dbfs_meter_top; predicts every read
// snapshot from its own copy of the meter state and compares field by field
module tb;
  import apm_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic        cfg_index;
  logic [19:0] cfg_data;

  audio_peak_rms_dbfs_meter_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model of the meter state and its registers
  logic [16:0] m_alpha;
  logic [19:0] m_stale;
  logic [15:0] m_peak;
  logic [42:0] m_sumsq;
  logic [12:0] m_count;
  logic signed [15:0] m_peak_db;
  logic [31:0] m_rms_lin;
  logic [19:0] m_ticks;
  logic        m_fed;

  out_item_t snapshots_due[$];
  int  errors;
  int  reads_seen;
  longint cycles;
  bit  long_hold;
  bit  drain;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // limit reckoned from the slowest run with generous headroom
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd2_000_000) begin
      $display("** audio_peak_rms_dbfs_meter_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // q16.16 magnitude to 1/256 dBFS
  function automatic logic signed [15:0] level_db(input logic [31:0] x);
    int unsigned e;
    logic [63:0] y, lg, neg, mag;
    if (x == 0) return DB_FLOOR;
    if (x > LIN_FULL) x = LIN_FULL;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    y = (e <= 30) ? (64'(x) << (30 - e)) : (64'(x) >> (e - 30));
    lg = 64'(e) << 16;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        lg[15 - i] = 1'b1;
        y = y >> 1;
      end
    end
    neg = (64'd31 << 16) - lg;
    mag = (neg * 64'd394566 + (64'd1 << 23)) >> 24;
    if (mag > 64'd30720) mag = 64'd30720;
    return -$signed(16'(mag));
  endfunction

  function automatic void meter_clear();
    m_peak = 0; m_sumsq = 0; m_count = 0;
    m_peak_db = DB_FLOOR; m_rms_lin = RMS_FLOOR;
    m_ticks = 0; m_fed = 1'b0;
  endfunction

  function automatic void close_block();
    logic [63:0] rms, q, r, a, mix;
    rms = 0;
    if (m_count != 0) begin
      q = m_sumsq / m_count;
      r = m_sumsq % m_count;
      rms = int_sqrt((q << 32) + ((r << 32) / m_count));
    end
    m_peak_db = level_db({m_peak, 16'd0});
    a = (m_alpha > ALPHA_ONE) ? 64'd65536 : 64'(m_alpha);
    mix = (64'(m_rms_lin) * (64'd65536 - a) + rms * a + 64'd32768) >> 16;
    if (mix < RMS_FLOOR) mix = RMS_FLOOR;
    if (mix > LIN_FULL) mix = LIN_FULL;
    m_rms_lin = mix[31:0];
    m_ticks = 0; m_fed = 1'b1;
    m_peak = 0; m_sumsq = 0; m_count = 0;
  endfunction

  // advance the model by one accepted item, queueing a snapshot for reads
  function automatic void meter_step(input in_item_t it);
    logic [15:0] mag;
    out_item_t s;
    case (it.opcode)
      OP_SAMPLE: begin
        mag = it.sample[15] ? 16'(-$signed(17'(it.sample))) : it.sample;
        if (m_count < 13'(MAX_BLOCK_SAMPLES_DEF) && m_count != 13'h1fff
            && int'(m_count) < MAX_BLOCK_SAMPLES_DEF) begin
          if (mag > m_peak) m_peak = mag;
          m_sumsq = m_sumsq + 43'(32'(mag) * 32'(mag));
          m_count = m_count + 13'd1;
        end
        if (it.block_last) close_block();
      end
      OP_TICK: if (m_ticks < AGE_MAX) m_ticks = m_ticks + 20'd1;
      OP_CLEAR: meter_clear();
      default: begin
        s.age_ms = m_fed ? m_ticks : AGE_MAX;
        s.peak_level_db = m_peak_db;
        s.rms_level_db = level_db(m_rms_lin);
        if (!m_fed || s.age_ms > m_stale) begin
          s.peak_level_db = DB_FLOOR;
          s.rms_level_db = DB_FLOOR;
        end
        snapshots_due.push_back(s);
      end
    endcase
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (read %0d)", what, got, want, reads_seen);
    errors++;
  endtask

  // result side: random stalls, and one long hold-off so the meter backs up
  initial begin
    int w;
    out_stall = 1'b1;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      w = drain ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  // compare every accepted result with the oldest snapshot
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (snapshots_due.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        out_item_t e;
        e = snapshots_due.pop_front();
        if (out_item.peak_level_db !== e.peak_level_db)
          report("peak", out_item.peak_level_db, e.peak_level_db);
        if (out_item.rms_level_db !== e.rms_level_db)
          report("rms", out_item.rms_level_db, e.rms_level_db);
        if (out_item.age_ms !== e.age_ms)
          report("age", out_item.age_ms, e.age_ms);
      end
      reads_seen++;
    end
  end

  // valid stays up into the next item when it follows with no gap
  task automatic send(input in_item_t it, input bit no_gap);
    int w;
    w = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk iff !in_stall);
    meter_step(it);
  endtask

  function automatic in_item_t mk(input op_t op, input logic [15:0] s, input logic l);
    in_item_t it;
    it.opcode = op; it.sample = s; it.block_last = l;
    return it;
  endfunction

  // wait for every snapshot, then let the block-end work settle
  task automatic settle();
    in_valid <= 1'b0;
    drain = 1'b1;
    wait (snapshots_due.size() == 0);
    repeat (400) @(posedge clk);
    drain = 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [19:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ALPHA) m_alpha = v[16:0];
    else m_stale = v;
  endtask

  // one block of len random samples, the last one closing the block
  task automatic random_block(input int len);
    for (int i = 0; i < len; i++)
      send(mk(OP_SAMPLE, 16'($urandom), i == len - 1), 1'b0);
  endtask

  typedef struct {
    in_item_t it;
    bit check;
    out_item_t want;
  } row_t;

  row_t rows[$];

  function automatic void add(input in_item_t it, input bit chk,
                              input logic signed [15:0] pk,
                              input logic signed [15:0] rm, input logic [19:0] age);
    row_t r;
    r.it = it; r.check = chk;
    r.want.peak_level_db = pk; r.want.rms_level_db = rm; r.want.age_ms = age;
    rows.push_back(r);
  endfunction

  initial begin
    int n;
    errors = 0; reads_seen = 0; cycles = 0; long_hold = 0; drain = 0;
    rst = 1'b1;
    in_valid = 1'b0; in_item = '0;
    cfg_we = 1'b0; cfg_index = CFG_ALPHA; cfg_data = '0;
    m_alpha = ALPHA_RESET; m_stale = STALE_RESET;
    meter_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: never fed, full scale, extremes, ignored fields, clear
    add(mk(OP_READ, 16'h7fff, 1'b1), 1, DB_FLOOR, DB_FLOOR, AGE_MAX);
    add(mk(OP_TICK, 16'h8000, 1'b1), 0, 0, 0, 0);
    add(mk(OP_SAMPLE, 16'h8000, 1'b1), 0, 0, 0, 0);
    add(mk(OP_READ, 0, 0), 1, 16'sd0, 0, 0);
    add(mk(OP_SAMPLE, 16'h7fff, 1'b0), 0, 0, 0, 0);
    add(mk(OP_SAMPLE, 16'h0001, 1'b0), 0, 0, 0, 0);
    add(mk(OP_SAMPLE, 16'hffff, 1'b1), 0, 0, 0, 0);
    add(mk(OP_TICK, 0, 0), 0, 0, 0, 0);
    add(mk(OP_READ, 0, 0), 1, 0, 0, 0);
    add(mk(OP_SAMPLE, 16'h0000, 1'b1), 0, 0, 0, 0);
    add(mk(OP_READ, 16'h5555, 1'b1), 1, 0, 0, 0);
    add(mk(OP_SAMPLE, 16'h0001, 1'b1), 0, 0, 0, 0);
    add(mk(OP_READ, 0, 0), 1, 0, 0, 0);
    add(mk(OP_CLEAR, 16'h7fff, 1'b1), 0, 0, 0, 0);
    add(mk(OP_READ, 0, 0), 1, DB_FLOOR, DB_FLOOR, AGE_MAX);
    add(mk(OP_SAMPLE, 16'haaaa, 1'b1), 0, 0, 0, 0);
    add(mk(OP_READ, 0, 0), 1, 0, 0, 0);
    foreach (rows[i]) begin
      out_item_t w;
      bit fixed;
      fixed = rows[i].check && (i == 0 || i == 14);
      send(rows[i].it, 1'b0);
      if (fixed) begin
        // check the prediction against the typed-in value; both must agree
        w = snapshots_due[$];
        if (w !== rows[i].want) report("table row", i, 0);
      end
    end
    settle();

    // stale limit: zero makes any tick stale
    write_reg(CFG_STALE, 20'd0);
    send(mk(OP_READ, 0, 0), 1'b1);
    send(mk(OP_TICK, 0, 0), 1'b1);
    send(mk(OP_READ, 0, 0), 1'b1);
    settle();

    // long block at full weight of the new rms
    write_reg(CFG_STALE, 20'd999999);
    write_reg(CFG_ALPHA, 20'd65536);
    random_block(200);
    send(mk(OP_READ, 0, 0), 1'b1);
    settle();

    // alpha and stale settings incl. alpha zero and all ones (above one); random traffic
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(CFG_ALPHA, 20'd0);
        1: write_reg(CFG_ALPHA, 20'h1ffff);
        2: write_reg(CFG_STALE, 20'hfffff);
        3: write_reg(CFG_ALPHA, 20'(ALPHA_RESET));
        4: write_reg(CFG_STALE, 20'd5);
        default: write_reg(CFG_ALPHA, 20'($urandom_range(1, 65535)));
      endcase
      if (ph == 2) long_hold = 1'b1;
      n = 0;
      while (n < 150) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            int len;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40)
                                              : $urandom_range(1, 6);
            random_block(len);
            n += len;
          end
          5, 6: begin
            send(mk(OP_TICK, 16'($urandom), 1'($urandom)), 1'b0);
            n++;
          end
          7, 8: begin
            send(mk(OP_READ, 16'($urandom), 1'($urandom)), ph == 2);
            n++;
          end
          default: begin
            if ($urandom_range(0, 3) == 0)
              send(mk(OP_CLEAR, 16'($urandom), 1'($urandom)), 1'b0);
            else
              send(mk(OP_SAMPLE, 16'($urandom), 1'b0), 1'b0);
            n++;
          end
        endcase
      end
      send(mk(OP_READ, 0, 0), 1'b0);
      settle();
    end

    if (errors == 0 && snapshots_due.size() == 0) begin
      $display("** audio_peak_rms_dbfs_meter_top: PASSED **");
    end else begin
      $display("** audio_peak_rms_dbfs_meter_top: FAILED **");
    end
    $finish;
  end
endmodule
